[hdl/lbc_pkg.sv]
// Shared types and constants for the LRU block cache.
package lbc_pkg;

	localparam int KIND_W = 3;
	localparam int TAG_W = 31;
	localparam int CNT_W = 32;
	localparam int CAP_W = 7;
	localparam int WORD_W = 64;

	localparam logic [KIND_W-1:0] OP_GET = 3'd0;
	localparam logic [KIND_W-1:0] OP_PUT = 3'd1;
	localparam logic [KIND_W-1:0] OP_REMOVE = 3'd2;
	localparam logic [KIND_W-1:0] OP_CLEAR = 3'd3;
	localparam logic [KIND_W-1:0] OP_PROBE = 3'd4;

	// Operation beat
	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [TAG_W-1:0] blk_num;
		logic [WORD_W-1:0] block_data;
	} lbc_op_t;

	// Result beat
	typedef struct packed {
		logic found;
		logic [WORD_W-1:0] read_data;
		logic evicted;
		logic [TAG_W-1:0] evicted_block;
		logic [CAP_W-1:0] blocks_held;
		logic [CNT_W-1:0] hit_count;
		logic [CNT_W-1:0] miss_count;
	} lbc_res_t;

	// Controller to datapath commands
	typedef struct packed {
		logic load;       // capture input beat, start lookup
		logic match;      // register tag compare
		logic scan_step;  // walk one slot of the victim/free scan
		logic scan_init;  // reset scan pointer
		logic commit;     // apply update, fill result register
	} lbc_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic scan_done;
		logic need_scan;
	} lbc_sts_t;

endpackage

[hdl/lbc_if.sv]
// Valid/ready channel interface carrying a payload of configurable type.
interface lbc_if #(parameter type payload_t = logic) ();
	logic valid;
	logic ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

[hdl/lbc_ctrl.sv]
// Sequencing controller for the LRU block cache.
module lbc_ctrl import lbc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	input  lbc_sts_t sts,
	output lbc_cmd_t cmd
);

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_MATCH  = 5'b00010,
		ST_SCAN   = 5'b00100,
		ST_COMMIT = 5'b01000,
		ST_OUT    = 5'b10000
	} state_t;

	state_t state_q, state_d;

	// Next state
	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_ready = 1'b0;
		out_valid = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d = ST_MATCH;
				end
			end
			ST_MATCH: begin
				cmd.match = 1'b1;
				cmd.scan_init = 1'b1;
				state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (!sts.need_scan || sts.scan_done) begin
					state_d = ST_COMMIT;
				end else begin
					cmd.scan_step = 1'b1;
				end
			end
			ST_COMMIT: begin
				cmd.commit = 1'b1;
				state_d = ST_OUT;
			end
			ST_OUT: begin
				out_valid = 1'b1;
				if (out_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

`ifndef SYNTH
	a_onehot: assert property (@(posedge clk) disable iff (!arst_n) $onehot(state_q))
		else $error("state not one-hot");
	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> state_q == ST_IDLE) else $error("load outside idle");
	a_commit_out: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> out_valid) else $error("commit without result");
`endif

endmodule

[hdl/lbc_dp.sv]
// Datapath of the LRU block cache: stores, tag compare, scan and update.
module lbc_dp import lbc_pkg::*; #(
	parameter int ENTRIES = 64,
	parameter int DATA_BITS = 64
) (
	input  logic clk,
	input  logic arst_n,
	input  lbc_cmd_t cmd,
	output lbc_sts_t sts,
	input  logic cap_we,
	input  logic [CAP_W-1:0] cap_wdata,
	input  logic [KIND_W-1:0] in_kind,
	input  logic [TAG_W-1:0] in_blk_num,
	input  logic [WORD_W-1:0] in_block_data,
	output logic r_found,
	output logic [WORD_W-1:0] r_read_data,
	output logic r_evicted,
	output logic [TAG_W-1:0] r_evicted_block,
	output logic [CAP_W-1:0] r_blocks_held,
	output logic [CNT_W-1:0] r_hit_count,
	output logic [CNT_W-1:0] r_miss_count
);

	localparam int IDX_W = $clog2(ENTRIES);
	localparam int HELD_W = $clog2(ENTRIES + 1);
	localparam int AGE_W = IDX_W;

	// Stores
	logic [TAG_W-1:0] tag_q [ENTRIES];
	logic [DATA_BITS-1:0] data_q [ENTRIES];
	logic [ENTRIES-1:0] valid_q;
	logic [AGE_W-1:0] age_q [ENTRIES];
	logic [HELD_W-1:0] held_q;
	logic [CNT_W-1:0] hits_q, misses_q;
	logic [CAP_W-1:0] cap_q;

	// Captured beat
	logic [KIND_W-1:0] kind_q;
	logic [TAG_W-1:0] key_q;
	logic [DATA_BITS-1:0] wdata_q;

	// Lookup results
	logic [ENTRIES-1:0] hit_vec;
	logic found_q;
	logic [IDX_W-1:0] hit_idx_q;
	logic [AGE_W-1:0] hit_age_q;

	// Scan
	logic [HELD_W-1:0] scan_q;
	logic slot_ok_q;
	logic [IDX_W-1:0] slot_q;
	logic evict_q;

	// Result registers
	logic [WORD_W-1:0] rd_q;
	logic ev_q;
	logic [TAG_W-1:0] evb_q;

	// Effective capacity and eviction decision
	logic [HELD_W:0] cap_eff;
	logic full;
	always_comb begin
		if (cap_q == '0) cap_eff = (HELD_W+1)'(1);
		else if ({{(HELD_W+1){1'b0}}, cap_q} > (HELD_W+CAP_W+1)'(ENTRIES))
			cap_eff = (HELD_W+1)'(ENTRIES);
		else cap_eff = (HELD_W+1)'(cap_q);
		full = ({1'b0, held_q} >= cap_eff) && (held_q != '0);
	end

	logic is_new_put;
	logic new_slot;
	assign is_new_put = (kind_q == OP_PUT) && !found_q;
	assign new_slot = is_new_put && slot_ok_q;
	assign sts.need_scan = is_new_put;
	assign sts.scan_done = (scan_q == HELD_W'(ENTRIES)) || slot_ok_q;

	// Parallel tag compare
	always_comb begin
		for (int i = 0; i < ENTRIES; i++)
			hit_vec[i] = valid_q[i] && (tag_q[i] == key_q);
	end

	logic [IDX_W-1:0] hit_idx;
	always_comb begin
		hit_idx = '0;
		for (int i = 0; i < ENTRIES; i++)
			if (hit_vec[i]) hit_idx = IDX_W'(i);
	end

	logic [IDX_W-1:0] scan_idx;
	assign scan_idx = scan_q[IDX_W-1:0];
	logic [AGE_W-1:0] held_m1;
	assign held_m1 = AGE_W'(held_q - HELD_W'(1));

	// Control of capture, lookup and scan
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_W'(64);
			found_q <= 1'b0;
			hit_idx_q <= '0;
			hit_age_q <= '0;
			scan_q <= '0;
			slot_ok_q <= 1'b0;
			slot_q <= '0;
			evict_q <= 1'b0;
		end else begin
			if (cap_we) cap_q <= cap_wdata;
			if (cmd.match) begin
				found_q <= |hit_vec;
				hit_idx_q <= hit_idx;
				hit_age_q <= age_q[hit_idx];
			end
			if (cmd.scan_init) begin
				scan_q <= '0;
				slot_ok_q <= 1'b0;
				evict_q <= 1'b0;
			end else if (cmd.scan_step) begin
				scan_q <= scan_q + HELD_W'(1);
				// victim: oldest valid entry; free: lowest invalid slot
				if (full ? (valid_q[scan_idx] && age_q[scan_idx] == held_m1)
					: !valid_q[scan_idx]) begin
					slot_ok_q <= 1'b1;
					slot_q <= scan_idx;
					evict_q <= full;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q <= in_kind;
			key_q <= in_blk_num;
			wdata_q <= in_block_data[DATA_BITS-1:0];
		end
	end

	// Commit: recency, validity and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			held_q <= '0;
			hits_q <= '0;
			misses_q <= '0;
			for (int i = 0; i < ENTRIES; i++) age_q[i] <= '0;
		end else if (cmd.commit) begin
			case (kind_q)
				OP_GET: begin
					if (found_q) begin
						for (int i = 0; i < ENTRIES; i++)
							if (valid_q[i] && age_q[i] < hit_age_q) age_q[i] <= age_q[i] + 1'b1;
						age_q[hit_idx_q] <= '0;
						if (hits_q != '1) hits_q <= hits_q + 1'b1;
					end else if (misses_q != '1) begin
						misses_q <= misses_q + 1'b1;
					end
				end
				OP_PUT: begin
					if (found_q) begin
						for (int i = 0; i < ENTRIES; i++)
							if (valid_q[i] && age_q[i] < hit_age_q) age_q[i] <= age_q[i] + 1'b1;
						age_q[hit_idx_q] <= '0;
					end else if (slot_ok_q) begin
						// evicting the oldest leaves others' ranks; the rest age by one
						for (int i = 0; i < ENTRIES; i++)
							if (valid_q[i] && IDX_W'(i) != slot_q) age_q[i] <= age_q[i] + 1'b1;
						age_q[slot_q] <= '0;
						valid_q[slot_q] <= 1'b1;
						if (!evict_q) held_q <= held_q + HELD_W'(1);
					end
				end
				OP_REMOVE: begin
					if (found_q) begin
						for (int i = 0; i < ENTRIES; i++)
							if (valid_q[i] && age_q[i] > hit_age_q) age_q[i] <= age_q[i] - 1'b1;
						age_q[hit_idx_q] <= '0;
						valid_q[hit_idx_q] <= 1'b0;
						held_q <= held_q - HELD_W'(1);
					end
				end
				OP_CLEAR: begin
					valid_q <= '0;
					held_q <= '0;
					for (int i = 0; i < ENTRIES; i++) age_q[i] <= '0;
				end
				default: ;
			endcase
		end
	end

	// Commit: tag/data stores and result payload
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			rd_q <= (kind_q == OP_GET && found_q) ? WORD_W'(data_q[hit_idx_q]) : '0;
			ev_q <= new_slot && evict_q;
			evb_q <= (new_slot && evict_q) ? tag_q[slot_q] : '0;
			if (kind_q == OP_PUT && found_q)
				data_q[hit_idx_q] <= wdata_q;
			if (new_slot) begin
				tag_q[slot_q] <= key_q;
				data_q[slot_q] <= wdata_q;
			end
		end
	end

	assign r_found = found_q;
	assign r_read_data = rd_q;
	assign r_evicted = ev_q;
	assign r_evicted_block = evb_q;
	assign r_blocks_held = CAP_W'(held_q);
	assign r_hit_count = hits_q;
	assign r_miss_count = misses_q;

`ifndef SYNTH
	a_held_match: assert property (@(posedge clk) disable iff (!arst_n)
		held_q == HELD_W'($countones(valid_q))) else $error("occupancy mismatch");
	a_no_dup: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.scan_init |=> $onehot0(hit_vec)) else $error("duplicate tag");
	a_evict_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit && evict_q && is_new_put |-> held_q != '0) else $error("evict from empty");
`endif

endmodule

[hdl/lru_block_cache.sv]
// Top level of the fully associative LRU block cache.
// One operation per input beat; one result beat each. The result is offered
// once the operation beat has passed capture, tag compare, scan and commit;
// for a put of a new block the scan walks up to ENTRIES slots, one slot a
// cycle, for the victim or the lowest free slot. One item is in flight at a
// time: the next beat is taken the cycle after the result beat, and an item
// stays longer while the result side stalls.
// Capacity must be written by the user only while idle; the block itself does not enforce it.
module lru_block_cache import lbc_pkg::*; #(
	parameter int ENTRIES = 64,
	parameter int DATA_BITS = 64
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [CAP_W-1:0] cfg_wdata,
	lbc_if.sink op,
	lbc_if.source res
);

	lbc_cmd_t cmd;
	lbc_sts_t sts;

	lbc_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(op.valid), .in_ready(op.ready),
		.out_valid(res.valid), .out_ready(res.ready),
		.sts(sts), .cmd(cmd)
	);

	lbc_dp #(.ENTRIES(ENTRIES), .DATA_BITS(DATA_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.cap_we(cfg_we), .cap_wdata(cfg_wdata),
		.in_kind(op.payload.kind),
		.in_blk_num(op.payload.blk_num),
		.in_block_data(op.payload.block_data),
		.r_found(res.payload.found),
		.r_read_data(res.payload.read_data),
		.r_evicted(res.payload.evicted),
		.r_evicted_block(res.payload.evicted_block),
		.r_blocks_held(res.payload.blocks_held),
		.r_hit_count(res.payload.hit_count),
		.r_miss_count(res.payload.miss_count)
	);

endmodule
